// ===== rtl/fgz_pkg.sv =====
// Package for the fission gas zone release unit.
// Holds stream layout, zone codes, register indexes and fixed-point constants.
// No dependencies.
package fgz_pkg;

  // Point store geometry
  localparam int unsigned NUM_POINTS = 64;
  localparam int unsigned PT_AW      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  // Stream widths (fields packed from bit 0 up, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 120;

  // Field widths
  localparam int unsigned GAS_W   = 48;
  localparam int unsigned STORE_W = 2 + 2 * GAS_W;

  // Zone codes
  localparam logic [1:0] ZONE1 = 2'd0;
  localparam logic [1:0] ZONE3 = 2'd1;
  localparam logic [1:0] ZONE4 = 2'd2;
  localparam logic [1:0] ZONE_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_YIELD    = 3'd0;
  localparam logic [2:0] CFG_NITROGEN = 3'd1;
  localparam logic [2:0] CFG_Z3_WIDTH = 3'd2;
  localparam logic [2:0] CFG_REL_Z1   = 3'd3;
  localparam logic [2:0] CFG_REL_Z3   = 3'd4;
  localparam logic [2:0] CFG_REL_Z4   = 3'd5;

  // Gas divisor 1204400000000 = 2^10 * GAS_DIV_ODD; reciprocal of the odd part in Q.63
  localparam logic [30:0] GAS_DIV_ODD   = 31'd1176171875;
  localparam logic [32:0] GAS_RECIP     = 33'(64'h8000_0000_0000_0000 / 64'(GAS_DIV_ODD));
  localparam logic [6:0]  GAS_FIX_STEPS = 7'd2;

  // Arithmetic constants
  localparam logic [35:0] B_BASE       = 36'd13107200000;
  localparam logic [33:0] A_BASE       = 34'd9502720000;
  localparam logic [18:0] RLN2_Q16     = 19'd377673;
  localparam logic [19:0] BURNUP_MIN   = 20'd1000;
  localparam logic [23:0] BURNUP_SCALE = 24'd10000000;
  localparam logic [7:0]  C_CUBE       = 8'd136;
  localparam logic [12:0] C_SQUARE     = 13'd4290;
  localparam logic [16:0] C_LINEAR     = 17'd71500;
  localparam logic [9:0]  C_A_SLOPE    = 10'd514;
  localparam logic [6:0]  DIV_STEPS    = 7'd73;
  localparam logic [4:0]  LOG_STEPS    = 5'd24;

endpackage

// ===== rtl/fission_gas_zone_release_unit.sv =====
// Fission gas zone release unit: top level with sequencer and shared datapath.
// Depends on fgz_pkg and fgz_ram.
//
// A first-step transaction goes from the store load straight to the hand-off;
// below the burnup threshold the T2, zone and release steps are skipped.
// Throughput: one transaction at a time; ready again as the result enters the
// output register, with a wait in S_FIN while that register is full and untaken.
// The rate is set by the bit-serial T2 divider (73 steps) and by the 48 squarings
// and two normalizations of the log2 evaluations on the single shared multiplier.
// Reset: asynchronous, active low; clears the sequencer, the output valid and the
// per-point valid bits (points read as zone 4, zero gas until written), and loads
// the configuration registers with their default values.
module fission_gas_zone_release_unit
  import fgz_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_index[5:0], temperature[21:6], fission_rate_now[53:22],
  // fission_rate_prev[85:54], burnup[105:86], step_seconds[129:106]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // first_step[0]
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // zone_code[1:0], gas_generated[49:2], gas_released[97:50], critical_temp[113:98]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_G0, S_G1, S_G2, S_G3,
    S_GQ0, S_GQ1, S_GQ2, S_GFIX, S_GSUM,
    S_N0, S_N1, S_N2, S_N3, S_N4, S_N5, S_N6, S_N7,
    S_NORM, S_SQ0, S_SQ1, S_T2M, S_T2D, S_DIVT, S_ZONE, S_REL, S_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [15:0] yield_q, nitro_q, z3w_q, rz1_q, rz3_q, rz4_q;

  // Captured transaction
  logic [PT_AW-1:0] addr_q;
  logic             in_rng_q, hit_q, first_q;
  logic [15:0]      temp_q;
  logic [32:0]      sum_q;
  logic [19:0]      burnup_q;
  logic [23:0]      dt_q;

  // Old point state
  logic [1:0]       zone_old_q;
  logic [GAS_W-1:0] gen_old_q, rel_old_q;

  // Working registers
  logic [7:0]       ydh_q;
  logic [72:0]      acc_q;
  logic [72:0]      dq_q;
  logic [47:0]      rem_q, dvs_q;
  logic [6:0]       cnt_q;
  logic [32:0]      dg_q;
  logic [63:0]      gres_q;
  logic [31:0]      nn_q;
  logic [35:0]      bq_q;
  logic [33:0]      aq_q;
  logic [63:0]      x_q;
  logic [5:0]       sh_q;
  logic [31:0]      y_q;
  logic [23:0]      frac_q;
  logic             log_sel_q;
  logic [30:0]      lnum_q;
  logic [30:0]      lb_q;

  // Results
  logic [1:0]       zone_q;
  logic [GAS_W-1:0] gen_q, rel_q;
  logic [15:0]      t2_q;

  // Output register
  logic             m_valid_q;
  logic [1:0]       out_zone_q;
  logic [GAS_W-1:0] out_gen_q, out_rel_q;
  logic [15:0]      out_t2_q;

  // Per-point valid bits
  logic [NUM_POINTS-1:0] pt_valid_q;

  // Shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_q;

  // Store interface
  logic               ram_we, ram_re;
  logic [PT_AW-1:0]   in_addr;
  logic [STORE_W-1:0] ram_wdata, ram_rdata;

  // Input field views
  logic [5:0]  in_idx;
  logic [15:0] in_temp;
  logic [31:0] in_now, in_prev;
  logic [19:0] in_burnup;
  logic [23:0] in_dt;

  assign in_idx    = s_axis_tdata[5:0];
  assign in_temp   = s_axis_tdata[21:6];
  assign in_now    = s_axis_tdata[53:22];
  assign in_prev   = s_axis_tdata[85:54];
  assign in_burnup = s_axis_tdata[105:86];
  assign in_dt     = s_axis_tdata[129:106];
  assign in_addr   = PT_AW'(in_idx);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, out_t2_q, out_rel_q, out_gen_q, out_zone_q};

  // Divider step: restoring, one quotient bit per cycle
  logic [48:0] div_r;
  logic        div_ge;
  logic [47:0] div_rem;
  logic [72:0] div_dq;

  always_comb begin
    div_r   = {rem_q, dq_q[72]};
    div_ge  = (div_r >= {1'b0, dvs_q});
    div_rem = div_ge ? 48'(div_r - {1'b0, dvs_q}) : div_r[47:0];
    div_dq  = {dq_q[71:0], div_ge};
  end

  // Generated total with saturation
  logic [48:0]      gen_sum;
  logic [GAS_W-1:0] gen_sat;

  always_comb begin
    gen_sum = {1'b0, gen_old_q} + 49'(dg_q);
    gen_sat = gen_sum[48] ? {GAS_W{1'b1}} : gen_sum[47:0];
  end

  // Released total with saturation
  logic [48:0]      rel_sum;
  logic [GAS_W-1:0] rel_sat;

  always_comb begin
    rel_sum = {1'b0, rel_old_q} + 49'(mul_q[49:17]);
    rel_sat = rel_sum[48] ? {GAS_W{1'b1}} : rel_sum[47:0];
  end

  // Squaring step of the log2 unit
  logic [32:0] sq_s;
  logic [31:0] sq_y;
  logic [23:0] sq_frac;

  always_comb begin
    sq_s    = mul_q[63:31];
    sq_y    = sq_s[32] ? sq_s[32:1] : sq_s[31:0];
    sq_frac = {frac_q[22:0], sq_s[32]};
  end

  // Log difference and zone decision
  logic signed [31:0] ldiff;
  logic [1:0]         zone_mid, zone_new;
  logic [16:0]        fsum;

  function automatic logic [15:0] zone_frac(input logic [1:0] code, input logic [15:0] f1,
                                            input logic [15:0] f3, input logic [15:0] f4);
    logic [15:0] r;
    case (code)
      ZONE1:   r = f1;
      ZONE3:   r = f3;
      default: r = f4;
    endcase
    return r;
  endfunction

  always_comb begin
    ldiff    = signed'({1'b0, lnum_q}) - signed'({1'b0, lb_q});
    zone_mid = ((zone_old_q == ZONE4) && (temp_q > t2_q)) ? ZONE3 : zone_old_q;
    zone_new = ((zone_mid == ZONE3) && ({1'b0, temp_q} > ({1'b0, t2_q} + {1'b0, z3w_q})))
               ? ZONE1 : zone_mid;
    fsum     = {1'b0, zone_frac(zone_new, rz1_q, rz3_q, rz4_q)}
             + {1'b0, zone_frac(zone_old_q, rz1_q, rz3_q, rz4_q)};
  end

  // Select multiplier operands for the step in progress
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_G0:    begin mul_a = 33'(yield_q);   mul_b = 33'(dt_q);           end
      S_G1:    begin mul_a = sum_q;          mul_b = 33'(mul_q[31:0]);    end
      S_G2:    begin mul_a = sum_q;          mul_b = 33'(ydh_q);          end
      S_GQ0:   begin mul_a = dq_q[72:40];    mul_b = GAS_RECIP;           end
      S_GQ1:   begin mul_a = mul_q[65:33];   mul_b = 33'(GAS_DIV_ODD);    end
      S_N0:    begin mul_a = 33'(nitro_q);   mul_b = 33'(nitro_q);        end
      S_N1:    begin mul_a = 33'(nitro_q);   mul_b = 33'(C_CUBE);         end
      S_N2:    begin mul_a = 33'(nn_q);      mul_b = 33'(mul_q[23:0]);    end
      S_N3:    begin mul_a = 33'(nn_q);      mul_b = 33'(C_SQUARE);       end
      S_N4:    begin mul_a = 33'(nitro_q);   mul_b = 33'(C_LINEAR);       end
      S_N5:    begin mul_a = 33'(nitro_q);   mul_b = 33'(C_A_SLOPE);      end
      S_N6:    begin mul_a = 33'(burnup_q);  mul_b = 33'(BURNUP_SCALE);   end
      S_SQ0:   begin mul_a = 33'(y_q);       mul_b = 33'(y_q);            end
      S_T2M:   begin mul_a = 33'(ldiff[29:0]); mul_b = 33'(RLN2_Q16);     end
      S_ZONE:  begin mul_a = dg_q;           mul_b = 33'(fsum);           end
      default: begin mul_a = '0;             mul_b = '0;                  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Point state store
  logic out_free;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign ram_re    = (state_q == S_IDLE) && s_axis_tvalid;
  assign ram_we    = (state_q == S_FIN) && out_free && in_rng_q;
  assign ram_wdata = {rel_q, gen_q, zone_q};

  fgz_ram #(
    .WIDTH (STORE_W),
    .DEPTH (NUM_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      pt_valid_q <= '0;
      yield_q    <= 16'd16384;
      nitro_q    <= 16'd0;
      z3w_q      <= 16'd1600;
      rz1_q      <= 16'd45875;
      rz3_q      <= 16'd9830;
      rz4_q      <= 16'd6554;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_YIELD:    yield_q <= cfg_data_i;
          CFG_NITROGEN: nitro_q <= cfg_data_i;
          CFG_Z3_WIDTH: z3w_q   <= cfg_data_i;
          CFG_REL_Z1:   rz1_q   <= cfg_data_i;
          CFG_REL_Z3:   rz3_q   <= cfg_data_i;
          CFG_REL_Z4:   rz4_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the output once taken, unless a new result loads in its place
      if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        // Capture the transaction and start the store read
        S_IDLE: begin
          if (s_axis_tvalid) begin
            addr_q   <= in_addr;
            in_rng_q <= (32'(in_idx) < NUM_POINTS);
            hit_q    <= (32'(in_idx) < NUM_POINTS) && pt_valid_q[in_addr];
            first_q  <= s_axis_tuser;
            temp_q   <= in_temp;
            sum_q    <= {1'b0, in_now} + {1'b0, in_prev};
            burnup_q <= in_burnup;
            dt_q     <= in_dt;
            state_q  <= S_LOAD;
          end
        end
        // Latch the old point state
        S_LOAD: begin
          if (hit_q) begin
            zone_old_q <= (ram_rdata[1:0] == ZONE_NONE) ? ZONE4 : ram_rdata[1:0];
            gen_old_q  <= ram_rdata[GAS_W+1:2];
            rel_old_q  <= ram_rdata[2*GAS_W+1:GAS_W+2];
          end else begin
            zone_old_q <= ZONE4;
            gen_old_q  <= '0;
            rel_old_q  <= '0;
          end
          if (first_q) begin
            zone_q  <= ZONE4;
            gen_q   <= '0;
            rel_q   <= '0;
            t2_q    <= 16'hFFFF;
            state_q <= S_FIN;
          end else begin
            state_q <= S_G0;
          end
        end
        // Gas product: yield*dt, then times the rate sum in two parts
        S_G0: state_q <= S_G1;
        S_G1: begin
          ydh_q   <= mul_q[39:32];
          state_q <= S_G2;
        end
        S_G2: begin
          acc_q   <= 73'(mul_q);
          state_q <= S_G3;
        end
        S_G3: begin
          dq_q    <= acc_q + {mul_q[40:0], 32'd0};
          state_q <= S_GQ0;
        end
        // Quotient estimate from the top bits times the reciprocal of the odd part
        S_GQ0: state_q <= S_GQ1;
        S_GQ1: begin
          dg_q    <= mul_q[65:33];
          state_q <= S_GQ2;
        end
        // Remainder of the product shifted down by 2^10; estimate is at most two low
        S_GQ2: begin
          gres_q  <= 64'(dq_q[72:10]) - mul_q[63:0];
          cnt_q   <= GAS_FIX_STEPS;
          state_q <= S_GFIX;
        end
        S_GFIX: begin
          if (gres_q >= 64'(GAS_DIV_ODD)) begin
            gres_q <= gres_q - 64'(GAS_DIV_ODD);
            dg_q   <= dg_q + 33'd1;
          end
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            state_q <= S_GSUM;
          end
        end
        // Add the step's gas; then branch on burnup
        S_GSUM: begin
          gen_q <= gen_sat;
          if (burnup_q < BURNUP_MIN) begin
            rel_q   <= '0;
            t2_q    <= 16'd0;
            zone_q  <= zone_old_q;
            state_q <= S_FIN;
          end else begin
            state_q <= S_N0;
          end
        end
        // Nitrogen polynomials for b and a
        S_N0: state_q <= S_N1;
        S_N1: begin
          nn_q    <= mul_q[31:0];
          state_q <= S_N2;
        end
        S_N2: state_q <= S_N3;
        S_N3: begin
          bq_q    <= B_BASE + 36'(mul_q[65:32]);
          state_q <= S_N4;
        end
        S_N4: begin
          bq_q    <= bq_q - mul_q[51:16];
          state_q <= S_N5;
        end
        S_N5: begin
          bq_q    <= bq_q + mul_q[35:0];
          state_q <= S_N6;
        end
        S_N6: begin
          aq_q    <= A_BASE - mul_q[33:0];
          state_q <= S_N7;
        end
        S_N7: begin
          x_q       <= mul_q[63:0];
          sh_q      <= '0;
          log_sel_q <= 1'b0;
          state_q   <= S_NORM;
        end
        // Normalize: shift by a byte where the top byte is clear, else by one
        S_NORM: begin
          if (x_q[63]) begin
            y_q     <= x_q[63:32];
            frac_q  <= '0;
            cnt_q   <= 7'(LOG_STEPS);
            state_q <= S_SQ0;
          end else if (x_q[63:56] == 8'd0) begin
            x_q  <= {x_q[55:0], 8'd0};
            sh_q <= sh_q + 6'd8;
          end else begin
            x_q  <= {x_q[62:0], 1'b0};
            sh_q <= sh_q + 6'd1;
          end
        end
        // Fraction bits by repeated squaring
        S_SQ0: state_q <= S_SQ1;
        S_SQ1: begin
          y_q    <= sq_y;
          frac_q <= sq_frac;
          cnt_q  <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            if (!log_sel_q) begin
              lnum_q    <= {7'(6'd63 - sh_q) + 7'd16, sq_frac};
              x_q       <= 64'(bq_q);
              sh_q      <= '0;
              log_sel_q <= 1'b1;
              state_q   <= S_NORM;
            end else begin
              lb_q    <= {7'(6'd63 - sh_q), sq_frac};
              state_q <= S_T2M;
            end
          end else begin
            state_q <= S_SQ0;
          end
        end
        // Scale the log difference by R ln2
        S_T2M: begin
          if (ldiff <= 32'sd0) begin
            t2_q    <= 16'hFFFF;
            state_q <= S_ZONE;
          end else begin
            state_q <= S_T2D;
          end
        end
        S_T2D: begin
          dq_q    <= {11'd0, aq_q, 28'd0};
          dvs_q   <= mul_q[47:0];
          rem_q   <= '0;
          cnt_q   <= DIV_STEPS;
          state_q <= S_DIVT;
        end
        S_DIVT: begin
          dq_q  <= div_dq;
          rem_q <= div_rem;
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            t2_q    <= (|div_dq[72:16]) ? 16'hFFFF : div_dq[15:0];
            state_q <= S_ZONE;
          end
        end
        // Advance the zone and form the release increment
        S_ZONE: begin
          zone_q  <= zone_new;
          state_q <= S_REL;
        end
        S_REL: begin
          rel_q   <= rel_sat;
          state_q <= S_FIN;
        end
        // Hand off the result and write back the point
        S_FIN: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            out_zone_q <= zone_q;
            out_gen_q  <= gen_q;
            out_rel_q  <= rel_q;
            out_t2_q   <= t2_q;
            if (in_rng_q) begin
              pt_valid_q[addr_q] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fgz_ram.sv =====
// Generic single-port-write, registered-read RAM.
// Used for the per-point state store. No dependencies.
module fgz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fgz_checker.sv =====
// Port-level checker for the fission gas zone release unit, with its bind.
// Depends on fgz_pkg; attaches to fission_gas_zone_release_unit.
module fgz_checker
  import fgz_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_we_i,
  input logic [2:0]            cfg_index_i,
  input logic [15:0]           cfg_data_i
);

  // One transaction at a time: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // Unused zone code never leaves the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != ZONE_NONE))
    else $error("invalid zone code on output");

  // Released total never exceeds generated total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[97:50] <= m_axis_tdata[49:2]))
    else $error("released gas exceeds generated gas");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while stalled");

endmodule

bind fission_gas_zone_release_unit fgz_checker u_fgz_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for fission_gas_zone_release_unit.
// A directed table and then constrained-random steps are checked against typed expectations or an inline predictor.
// Depends on fgz_pkg and the unit's RTL.
module tb;
  import fgz_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned PHASE_ITEMS  = 325;

  typedef struct packed {
    logic [5:0]  idx;
    logic        first;
    logic [15:0] temp;
    logic [31:0] rate_now;
    logic [31:0] rate_prev;
    logic [19:0] burnup;
    logic [23:0] dt;
  } gas_step_t;

  typedef struct packed {
    logic [1:0]  zone;
    logic [47:0] gen;
    logic [47:0] rel;
    logic [15:0] t2;
  } gas_totals_t;

  typedef struct {
    gas_step_t   s;
    bit          typed;
    gas_totals_t r;
  } table_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_index_i = '0;
  logic [15:0]           cfg_data_i = '0;

  fission_gas_zone_release_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: register copies and per-point stores
  logic [15:0] yield_r, nitro_r, width_r, frac_z1_r, frac_z3_r, frac_z4_r;
  logic [1:0]  zone_mem [NUM_POINTS];
  logic [47:0] gen_mem  [NUM_POINTS];
  logic [47:0] rel_mem  [NUM_POINTS];

  gas_totals_t pending_q[$];
  int          fail_count = 0;
  int          results_seen = 0;
  int unsigned cycle_count = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;

  function automatic longint signed log2_q24(input logic [63:0] v);
    int          p;
    logic [63:0] y;
    logic [63:0] frac;
    p = 63;
    frac = '0;
    while (p > 0 && v[p] == 1'b0) p--;
    y = (p > 31) ? (v >> (p - 31)) : (v << (31 - p));
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return (longint'(p) <<< 24) | longint'(frac);
  endfunction

  function automatic logic [63:0] critical_temp(input logic [19:0] burnup);
    logic [63:0]    n;
    logic [63:0]    bq;
    logic [63:0]    aq;
    logic [63:0]    num;
    longint signed  diff;
    logic [63:0]    t;
    n = 64'(nitro_r);
    bq = 64'd13107200000 + 64'd71500 * n - ((64'd4290 * n * n) >> 16)
       + ((64'd136 * n * n * n) >> 32);
    aq = 64'd145000 * 64'd65536 - 64'd514 * n;
    num = 64'(burnup) * 64'd10000000 * 64'd65536;
    diff = log2_q24(num) - log2_q24(bq);
    if (diff <= 0) return 64'd65535;
    t = (aq << 28) / (64'd377673 * 64'(diff));
    return (t > 64'd65535) ? 64'd65535 : t;
  endfunction

  function automatic logic [63:0] zone_frac(input logic [1:0] z);
    if (z == ZONE1) return 64'(frac_z1_r);
    if (z == ZONE3) return 64'(frac_z3_r);
    return 64'(frac_z4_r);
  endfunction

  // Advance one point by one step and return its new totals
  function automatic gas_totals_t step_point(input gas_step_t s);
    gas_totals_t r;
    logic [1:0]  zone_old;
    logic [79:0] prod;
    logic [63:0] dg;
    logic [63:0] gen;
    logic [63:0] rel;
    logic [63:0] t2;
    zone_old = (zone_mem[s.idx] == ZONE_NONE) ? ZONE4 : zone_mem[s.idx];
    r = '0;
    if (s.first) begin
      r.zone = ZONE4;
      r.t2 = 16'hFFFF;
    end else begin
      prod = (80'(s.rate_now) + 80'(s.rate_prev)) * 80'(yield_r) * 80'(s.dt);
      dg = 64'(prod / 80'd1204400000000);
      gen = 64'(gen_mem[s.idx]) + dg;
      r.gen = (gen > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : gen[47:0];
      r.zone = zone_old;
      if (s.burnup >= 20'd1000) begin
        t2 = critical_temp(s.burnup);
        r.t2 = t2[15:0];
        if (r.zone == ZONE4 && 64'(s.temp) > t2) r.zone = ZONE3;
        if (r.zone == ZONE3 && 64'(s.temp) > t2 + 64'(width_r)) r.zone = ZONE1;
        rel = 64'(rel_mem[s.idx])
            + ((dg * (zone_frac(r.zone) + zone_frac(zone_old))) >> 17);
        r.rel = (rel > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : rel[47:0];
      end
    end
    zone_mem[s.idx] = r.zone;
    gen_mem[s.idx] = r.gen;
    rel_mem[s.idx] = r.rel;
    return r;
  endfunction

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (index)
      CFG_YIELD:    yield_r = value;
      CFG_NITROGEN: nitro_r = value;
      CFG_Z3_WIDTH: width_r = value;
      CFG_REL_Z1:   frac_z1_r = value;
      CFG_REL_Z3:   frac_z3_r = value;
      CFG_REL_Z4:   frac_z4_r = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] v [6]);
    write_reg(CFG_YIELD, v[0]);
    write_reg(CFG_NITROGEN, v[1]);
    write_reg(CFG_Z3_WIDTH, v[2]);
    write_reg(CFG_REL_Z1, v[3]);
    write_reg(CFG_REL_Z3, v[4]);
    write_reg(CFG_REL_Z4, v[5]);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every result is back and the unit has settled
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Offer one step, hold it until accepted, then queue its expected totals
  task automatic send_step(input gas_step_t s, input bit typed, input gas_totals_t r);
    int unsigned gap;
    gas_totals_t want;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, s.dt, s.burnup, s.rate_prev, s.rate_now, s.temp, s.idx};
    s_axis_tuser <= s.first;
    do @(posedge clk_i); while (!s_axis_tready);
    want = step_point(s);
    pending_q.push_back(typed ? r : want);
  endtask

  function automatic gas_step_t random_step();
    gas_step_t s;
    s.idx = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    s.first = ($urandom_range(0, 19) == 0);
    s.temp = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(12000, 40000));
    case ($urandom_range(0, 2))
      0: begin s.rate_now = $urandom; s.rate_prev = $urandom; end
      1: begin s.rate_now = $urandom_range(0, 1000000); s.rate_prev = $urandom_range(0, 1000000); end
      default: begin s.rate_now = $urandom_range(0, 65535); s.rate_prev = $urandom; end
    endcase
    s.burnup = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 999))
                                           : 20'($urandom_range(1000, 1000000));
    s.dt = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 100000));
    return s;
  endfunction

  function automatic table_row_t row(input logic [5:0] idx, input logic first,
                                     input logic [15:0] temp, input logic [31:0] rn,
                                     input logic [31:0] rp, input logic [19:0] bu,
                                     input logic [23:0] dt, input bit typed,
                                     input logic [1:0] z, input logic [15:0] t2);
    table_row_t t;
    t.s = '{idx, first, temp, rn, rp, bu, dt};
    t.typed = typed;
    t.r = '{z, 48'd0, 48'd0, t2};
    return t;
  endfunction

  // Stimulus
  initial begin
    table_row_t  dir_tab[$];
    logic [15:0] regs [6];
    yield_r = 16'd16384; nitro_r = 16'd0; width_r = 16'd1600;
    frac_z1_r = 16'd45875; frac_z3_r = 16'd9830; frac_z4_r = 16'd6554;
    for (int i = 0; i < NUM_POINTS; i++) begin
      zone_mem[i] = ZONE4; gen_mem[i] = '0; rel_mem[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First steps, low burnup, threshold edge, extremes, one point walked through zones
    dir_tab.push_back(row(6'd0, 1, 16'hFFFF, '1, '1, 20'd1000000, '1, 1, ZONE4, 16'hFFFF));
    dir_tab.push_back(row(6'd63, 1, 16'd0, 0, 0, 20'd0, 0, 1, ZONE4, 16'hFFFF));
    dir_tab.push_back(row(6'd1, 0, 16'hFFFF, 0, 0, 20'd999, '1, 1, ZONE4, 16'd0));
    dir_tab.push_back(row(6'd2, 0, 16'd0, 0, 0, 20'd0, 0, 1, ZONE4, 16'd0));
    dir_tab.push_back(row(6'd1, 0, 16'hFFFF, '1, '1, 20'd999, '1, 0, 0, 0));
    dir_tab.push_back(row(6'd3, 0, 16'd0, '1, '1, 20'd1000, '1, 0, 0, 0));
    dir_tab.push_back(row(6'd4, 0, 16'd0, '1, 0, 20'd1000000, 24'd1000, 0, 0, 0));
    dir_tab.push_back(row(6'd5, 0, 16'd21000, 32'd5000000, 32'd5000000, 20'd10000,
                          24'd86400, 0, 0, 0));
    dir_tab.push_back(row(6'd5, 0, 16'd22000, 32'd5000000, 32'd5000000, 20'd10000,
                          24'd86400, 0, 0, 0));
    dir_tab.push_back(row(6'd5, 0, 16'd40000, 32'd5000000, 32'd5000000, 20'd10000,
                          24'd86400, 0, 0, 0));
    dir_tab.push_back(row(6'd5, 0, 16'd0, 32'd5000000, 32'd5000000, 20'd10000,
                          24'd86400, 0, 0, 0));
    dir_tab.push_back(row(6'd6, 0, 16'hFFFF, '1, '1, 20'd1000, '1, 0, 0, 0));
    dir_tab.push_back(row(6'd6, 0, 16'hFFFF, '1, '1, 20'd1000000, '1, 0, 0, 0));
    dir_tab.push_back(row(6'd6, 0, 16'hFFFF, '1, '1, 20'd500, '1, 0, 0, 0));
    dir_tab.push_back(row(6'd7, 0, 16'd30000, 32'd123456, 32'd654321, 20'd54321, 24'd0,
                          0, 0, 0));
    dir_tab.push_back(row(6'd5, 1, 16'd40000, '1, '1, 20'd10000, '1, 1, ZONE4, 16'hFFFF));
    dir_tab.push_back(row(6'd42, 0, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555, 20'h55555,
                          24'hAAAAAA, 0, 0, 0));
    dir_tab.push_back(row(6'd21, 0, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 20'hAAAAA,
                          24'h555555, 0, 0, 0));
    foreach (dir_tab[i]) send_step(dir_tab[i].s, dir_tab[i].typed, dir_tab[i].r);
    s_axis_tvalid <= 1'b0;

    // Random phases, each under a different register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        1: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: regs = '{16'd16384, 16'd0, 16'd1600, 16'd45875, 16'd9830, 16'd6554};
        default: foreach (regs[k]) regs[k] = 16'($urandom);
      endcase
      write_all(regs);
      send_gaps = (ph != 3);
      recv_gaps = (ph != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) send_step(random_step(), 1'b0, '0);
      s_axis_tvalid <= 1'b0;
    end

    drain();
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, and one long hold-off to back the unit up
  initial begin
    int unsigned w;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      w = recv_gaps ? $urandom_range(0, 18) : 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    gas_totals_t got;
    gas_totals_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[1:0], m_axis_tdata[49:2], m_axis_tdata[97:50],
              m_axis_tdata[113:98]};
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (got.zone != want.zone) begin
          $error("zone_code: expected %0d, got %0d", want.zone, got.zone);
          fail_count++;
        end
        if (got.gen != want.gen) begin
          $error("gas_generated: expected %0d, got %0d", want.gen, got.gen);
          fail_count++;
        end
        if (got.rel != want.rel) begin
          $error("gas_released: expected %0d, got %0d", want.rel, got.rel);
          fail_count++;
        end
        if (got.t2 != want.t2) begin
          $error("critical_temp: expected %0d, got %0d", want.t2, got.t2);
          fail_count++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
